/* sv/vldd_pkg.sv */
// shared types and constants for the variable length delta decoder
`timescale 1ns / 1ps
`default_nettype none

package vldd_pkg;

  localparam int unsigned DefContexts = 4;
  localparam int unsigned NumChan     = 6;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned LenBits     = 4;
  localparam int unsigned ValBits     = 16;
  localparam int unsigned CtxReqW     = 2;

  localparam logic FuncStart = 1'b0;
  localparam logic FuncWord  = 1'b1;

  typedef struct packed {
    logic                func;
    logic [CtxReqW-1:0]  context_req;
    logic [WordBits-1:0] stream_word;
  } vldd_in_t;

  typedef struct packed {
    logic [CtxReqW-1:0]        out_context;
    logic signed [ValBits-1:0] chan0;
    logic signed [ValBits-1:0] chan1;
    logic signed [ValBits-1:0] chan2;
    logic signed [ValBits-1:0] chan3;
    logic signed [ValBits-1:0] chan4;
    logic signed [ValBits-1:0] chan5;
  } vldd_out_t;

  typedef enum logic [2:0] {
    VlddIdle,
    VlddLoad,
    VlddHeld,
    VlddWord,
    VlddStore,
    VlddEmit
  } vldd_state_e;

endpackage

`default_nettype wire

/* sv/variable_length_delta_decoder_top.sv */
// variable length delta decoder: bit serial field parser with per context state
// a word item passes through load, the held bits of its context, its own word bits
// and store, where held (0 to 31) is the count of bits left over in that context
// from earlier words; an item that completes a frame then waits in emit until the
// output is free; the parser takes one bit per cycle; items are taken only in idle
// reset clears every context, the state machine and the output valid flag at once
`timescale 1ns / 1ps
`default_nettype none

module variable_length_delta_decoder_top #(
  parameter int unsigned CONTEXTS = vldd_pkg::DefContexts
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire vldd_pkg::vldd_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output vldd_pkg::vldd_out_t     out_data_o
);
  import vldd_pkg::*;

  localparam int unsigned CtxW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam logic [2:0] LastChan = 3'(NumChan - 1);

  // per context state
  logic [WordBits-1:0] buf_mem_q   [CONTEXTS];
  logic [4:0]          left_mem_q  [CONTEXTS];
  logic [ValBits-1:0]  acc_mem_q   [CONTEXTS][NumChan];
  logic [2:0]          chan_mem_q  [CONTEXTS];
  logic                phase_mem_q [CONTEXTS];
  logic [LenBits-1:0]  plen_mem_q  [CONTEXTS];

  vldd_state_e state_q, state_d;
  logic        emitted_q, emitted_d;
  logic        out_valid_q;
  vldd_out_t   out_data_q;

  // working copy of one context
  logic [WordBits-1:0] hold_q;
  logic [4:0]          hcnt_q;
  logic [WordBits-1:0] word_q;
  logic [4:0]          wcnt_q;
  logic [CtxReqW-1:0]  ctx_q;
  logic [WordBits-1:0] tail_q, tail_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                phase_q, phase_d;
  logic [LenBits-1:0]  plen_q, plen_d;
  logic [2:0]          chan_q, chan_d;
  logic [ValBits-1:0]  acc_w_q [NumChan];
  logic [ValBits-1:0]  acc_d   [NumChan];
  logic [ValBits-1:0]  frame_q [NumChan];
  logic [ValBits-1:0]  frame_d [NumChan];

  logic               in_accept;
  logic [4:0]         in_ctx_ext;
  logic [4:0]         ctx_ext;
  logic               in_ctx_ok;
  logic [CtxW-1:0]    in_idx;
  logic [CtxW-1:0]    ctx_idx;
  logic               out_free;
  logic               load_out;
  logic               bit_s;
  logic [4:0]         hidx;
  logic [5:0]         cnt_inc;
  logic [4:0]         vlen;
  logic [ValBits-1:0] low_mask;
  logic [4:0]         sidx;
  logic               sign_s;
  logic [ValBits-1:0] sval;
  logic               blocked;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_ctx_ext = 5'(in_data_i.context_req);
  assign ctx_ext    = 5'(ctx_q);
  assign in_ctx_ok  = in_ctx_ext < 5'(CONTEXTS);
  assign in_idx     = in_ctx_ext[CtxW-1:0];
  assign ctx_idx    = ctx_ext[CtxW-1:0];
  assign out_free   = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      VlddIdle: begin
        if (in_accept && in_ctx_ok && in_data_i.func == FuncWord) begin
          state_d = VlddLoad;
        end
      end
      VlddLoad: begin
        state_d = (left_mem_q[ctx_idx] != 5'd0) ? VlddHeld : VlddWord;
      end
      VlddHeld: begin
        if (hcnt_q == 5'd1) begin
          state_d = VlddWord;
        end
      end
      VlddWord: begin
        if (wcnt_q == 5'd0) begin
          state_d = VlddStore;
        end
      end
      VlddStore: begin
        state_d = emitted_q ? VlddEmit : VlddIdle;
      end
      VlddEmit: begin
        if (out_free) begin
          state_d = VlddIdle;
        end
      end
      default: state_d = VlddIdle;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      VlddIdle: in_stall_o = 1'b0;
      VlddEmit: load_out   = out_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  // one stream bit through the field parser
  assign hidx  = hcnt_q - 5'd1;
  assign bit_s = (state_q == VlddHeld) ? hold_q[hidx] : word_q[WordBits-1];

  always_comb begin
    tail_d    = {tail_q[WordBits-2:0], bit_s};
    cnt_inc   = cnt_q + 6'd1;
    cnt_d     = cnt_inc;
    phase_d   = phase_q;
    plen_d    = plen_q;
    chan_d    = chan_q;
    emitted_d = emitted_q;
    acc_d     = acc_w_q;
    frame_d   = frame_q;
    vlen      = (plen_q == '0) ? 5'(ValBits) : 5'(plen_q);
    low_mask  = {ValBits{1'b1}} >> (5'(ValBits) - vlen);
    sidx      = vlen - 5'd1;
    sign_s    = tail_d[sidx];
    sval      = (tail_d[ValBits-1:0] & low_mask) | (sign_s ? ~low_mask : '0);
    blocked   = emitted_q && (chan_q == LastChan);
    if (!phase_q) begin
      if (cnt_inc == 6'(LenBits)) begin
        plen_d  = tail_d[LenBits-1:0];
        phase_d = 1'b1;
        cnt_d   = '0;
      end
    end else if (cnt_inc == 6'(vlen) && !blocked) begin
      acc_d[chan_q] = acc_w_q[chan_q] + sval;
      phase_d       = 1'b0;
      cnt_d         = '0;
      if (chan_q == LastChan) begin
        chan_d    = '0;
        emitted_d = 1'b1;
        frame_d   = acc_d;
      end else begin
        chan_d = chan_q + 3'd1;
      end
    end
  end

  // control and context store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= VlddIdle;
      emitted_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CONTEXTS; c++) begin
        buf_mem_q[c]   <= '0;
        left_mem_q[c]  <= '0;
        chan_mem_q[c]  <= '0;
        phase_mem_q[c] <= 1'b0;
        plen_mem_q[c]  <= '0;
        for (int k = 0; k < NumChan; k++) begin
          acc_mem_q[c][k] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        VlddIdle: begin
          if (in_accept && in_ctx_ok && in_data_i.func == FuncStart) begin
            buf_mem_q[in_idx]   <= '0;
            left_mem_q[in_idx]  <= '0;
            chan_mem_q[in_idx]  <= '0;
            phase_mem_q[in_idx] <= 1'b0;
            plen_mem_q[in_idx]  <= '0;
            for (int k = 0; k < NumChan; k++) begin
              acc_mem_q[in_idx][k] <= '0;
            end
          end
        end
        VlddLoad: emitted_q <= 1'b0;
        VlddHeld, VlddWord: emitted_q <= emitted_d;
        VlddStore: begin
          buf_mem_q[ctx_idx]   <= tail_q;
          left_mem_q[ctx_idx]  <= (cnt_q > 6'd31) ? 5'd31 : cnt_q[4:0];
          chan_mem_q[ctx_idx]  <= chan_q;
          phase_mem_q[ctx_idx] <= phase_q;
          plen_mem_q[ctx_idx]  <= plen_q;
          for (int k = 0; k < NumChan; k++) begin
            acc_mem_q[ctx_idx][k] <= acc_w_q[k];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      VlddIdle: begin
        if (in_accept) begin
          word_q <= in_data_i.stream_word;
          ctx_q  <= in_data_i.context_req;
        end
      end
      VlddLoad: begin
        hold_q  <= buf_mem_q[ctx_idx];
        hcnt_q  <= left_mem_q[ctx_idx];
        chan_q  <= chan_mem_q[ctx_idx];
        phase_q <= phase_mem_q[ctx_idx];
        plen_q  <= plen_mem_q[ctx_idx];
        cnt_q   <= '0;
        wcnt_q  <= 5'(WordBits - 1);
        for (int k = 0; k < NumChan; k++) begin
          acc_w_q[k] <= acc_mem_q[ctx_idx][k];
        end
      end
      VlddHeld, VlddWord: begin
        tail_q  <= tail_d;
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
        plen_q  <= plen_d;
        chan_q  <= chan_d;
        acc_w_q <= acc_d;
        frame_q <= frame_d;
        if (state_q == VlddHeld) begin
          hcnt_q <= hcnt_q - 5'd1;
        end else begin
          word_q <= {word_q[WordBits-2:0], 1'b0};
          wcnt_q <= wcnt_q - 5'd1;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_data_q.out_context <= ctx_q;
      out_data_q.chan0       <= $signed(frame_q[0]);
      out_data_q.chan1       <= $signed(frame_q[1]);
      out_data_q.chan2       <= $signed(frame_q[2]);
      out_data_q.chan3       <= $signed(frame_q[3]);
      out_data_q.chan4       <= $signed(frame_q[4]);
      out_data_q.chan5       <= $signed(frame_q[5]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_len_phase_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == VlddHeld || state_q == VlddWord) && !phase_q) |-> (cnt_q < 6'(LenBits)))
    else $error("length code overran its four bits");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == VlddHeld || state_q == VlddWord || state_q == VlddStore)
      |-> (chan_q < 3'(NumChan)))
    else $error("channel index out of range");

  a_emit_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == VlddEmit) |-> emitted_q)
    else $error("result stage entered without a completed frame");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == VlddEmit))
    else $error("result raised outside the result stage");

  a_word_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == VlddLoad) |=> (state_q == VlddHeld || state_q == VlddWord))
    else $error("load not followed by bit shifting");
`endif

endmodule

`default_nettype wire
